[src/assert_macros.svh]
// Assertion macros shared by the RTL of the linked queue block.
// Depends on nothing; under SYNTHESIS every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is held.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset.
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[src/lqc_pkg.sv]
// Types, sizes and codes of the linked queue with cursor.
// Used by linked_queue_with_cursor; depends on nothing.
package lqc_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int PW         = $clog2(DEPTH + 1);
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + PW + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_WIDTH - PW;

  typedef logic [AW-1:0]         addr_t;
  typedef logic [PW-1:0]         ptr_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam ptr_t NIL = PW'(DEPTH);

  typedef enum logic [2:0] {
    ACT_PUSH, ACT_POP, ACT_SEEK_FIRST, ACT_SEEK_LAST,
    ACT_STEP_NEXT, ACT_STEP_PREV, ACT_REMOVE, ACT_CLEAR
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK, STAT_EMPTY, STAT_FULL, STAT_NOCUR
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_LINK, ST_WR2, ST_RES
  } state_t;

  function automatic logic is_slot(ptr_t p);
    return (p < NIL);
  endfunction

endpackage

[src/linked_queue_with_cursor.sv]
// Linked queue with cursor: doubly linked FIFO in a slot store with free list.
// Depends on lqc_pkg and assert_macros.svh.
// Path from accept to result: seek, clear, empty pop and cursorless step or remove go to
// ST_RES; pop, step and a push onto an empty queue or into a full store pass ST_LINK; remove
// and a push onto a non-empty queue pass ST_LINK and ST_WR2. One transaction in flight.
// Reset (rst_n low, synchronous): queue empty, cursor dropped, direction forward.
`include "assert_macros.svh"

module linked_queue_with_cursor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lqc_pkg::IN_TDATA_W-1:0] in_tdata,   // [31:0] in_data
  input  logic [2:0]                     in_tuser,   // [2:0] action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lqc_pkg::OUT_TDATA_W-1:0] out_tdata, // [31:0] out_data, [36:32] occupancy
  output logic [3:0]                     out_tuser   // [1:0] status, [2] out_valid,
                                                     // [3] cursor_valid
);
  import lqc_pkg::*;

  // Slot store: payload words and both link directions
  word_t word_mem [DEPTH];
  ptr_t  fwd_mem  [DEPTH];
  ptr_t  bwd_mem  [DEPTH];

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  word_t   data_r, data_nxt;
  status_t stat_r, stat_nxt;
  ptr_t    head_r, head_nxt;
  ptr_t    tail_r, tail_nxt;
  ptr_t    cur_r, cur_nxt;
  logic    dir_r, dir_nxt;
  ptr_t    free_r, free_nxt;
  ptr_t    fresh_r, fresh_nxt;
  ptr_t    count_r, count_nxt;
  ptr_t    wr2_addr_r, wr2_addr_nxt;
  ptr_t    wr2_data_r, wr2_data_nxt;

  // Store read port (one address for all three arrays)
  logic    rd_en;
  addr_t   rd_addr;
  word_t   rd_word_r;
  ptr_t    rd_fwd_r;
  ptr_t    rd_bwd_r;

  // Store write ports
  logic    wd_we, fw_we, bw_we;
  addr_t   wd_addr, fw_addr, bw_addr;
  word_t   wd_data;
  ptr_t    fw_data, bw_data;

  // Result register
  logic    out_tvalid_r, out_tvalid_nxt;
  status_t out_stat_r, out_stat_nxt;
  word_t   out_word_r, out_word_nxt;
  logic    out_wv_r, out_wv_nxt;
  logic    out_cv_r, out_cv_nxt;
  ptr_t    out_occ_r, out_occ_nxt;

  logic    in_fire, out_free;
  action_t in_act;
  logic    slot_avail;
  ptr_t    push_slot;
  ptr_t    seek_sel;
  ptr_t    step_sel;
  ptr_t    rm_sel;
  logic    res_wv;

  assign in_act     = action_t'(in_tuser);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  // Recycled slots first, then never-used slots in order
  assign slot_avail = is_slot(free_r) || (fresh_r < NIL);
  assign push_slot  = is_slot(free_r) ? free_r : fresh_r;
  assign seek_sel   = (in_act == ACT_SEEK_FIRST) ? head_r : tail_r;
  assign step_sel   = dir_r ? rd_fwd_r : rd_bwd_r;
  // After a removal the cursor backs off against the direction of travel
  assign rm_sel     = dir_r ? rd_bwd_r : rd_fwd_r;
  // Popped word is valid on a good pop; otherwise the word under the cursor
  assign res_wv     = ((act_r == ACT_POP) && (stat_r == STAT_OK)) || is_slot(cur_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            ACT_PUSH:                     state_nxt = ST_LINK;
            ACT_POP:                      state_nxt = is_slot(head_r) ? ST_LINK : ST_RES;
            ACT_STEP_NEXT, ACT_STEP_PREV,
            ACT_REMOVE:                   state_nxt = is_slot(cur_r) ? ST_LINK : ST_RES;
            default:                      state_nxt = ST_RES;
          endcase
        end
      end
      ST_LINK: begin
        case (act_r)
          ACT_PUSH:   state_nxt = (slot_avail && is_slot(tail_r)) ? ST_WR2 : ST_RES;
          ACT_REMOVE: state_nxt = ST_WR2;
          default:    state_nxt = ST_RES;
        endcase
      end
      ST_WR2:  state_nxt = ST_RES;
      ST_RES:  state_nxt = out_free ? ST_IDLE : ST_RES;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store access and result
  always_comb begin
    act_nxt      = act_r;
    data_nxt     = data_r;
    stat_nxt     = stat_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cur_nxt      = cur_r;
    dir_nxt      = dir_r;
    free_nxt     = free_r;
    fresh_nxt    = fresh_r;
    count_nxt    = count_r;
    wr2_addr_nxt = wr2_addr_r;
    wr2_data_nxt = wr2_data_r;
    rd_en        = 1'b0;
    rd_addr      = cur_r[AW-1:0];
    wd_we        = 1'b0;
    wd_addr      = push_slot[AW-1:0];
    wd_data      = data_r;
    fw_we        = 1'b0;
    fw_addr      = wr2_addr_r[AW-1:0];
    fw_data      = wr2_data_r;
    bw_we        = 1'b0;
    bw_addr      = push_slot[AW-1:0];
    bw_data      = tail_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_stat_nxt = out_stat_r;
    out_word_nxt = out_word_r;
    out_wv_nxt   = out_wv_r;
    out_cv_nxt   = out_cv_r;
    out_occ_nxt  = out_occ_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt  = in_act;
          data_nxt = in_tdata[DATA_WIDTH-1:0];
          stat_nxt = STAT_OK;
          case (in_act)
            ACT_PUSH: begin
              // Fetch the free-list successor of the candidate slot
              cur_nxt = NIL;
              rd_en   = 1'b1;
              rd_addr = free_r[AW-1:0];
            end
            ACT_POP: begin
              cur_nxt = NIL;
              rd_addr = head_r[AW-1:0];
              if (is_slot(head_r)) begin
                rd_en = 1'b1;
              end else begin
                stat_nxt = STAT_EMPTY;
              end
            end
            ACT_SEEK_FIRST, ACT_SEEK_LAST: begin
              dir_nxt = (in_act == ACT_SEEK_FIRST);
              cur_nxt = seek_sel;
              rd_en   = 1'b1;
              rd_addr = seek_sel[AW-1:0];
              if (!is_slot(seek_sel)) begin
                stat_nxt = STAT_EMPTY;
              end
            end
            ACT_STEP_NEXT, ACT_STEP_PREV: begin
              dir_nxt = (in_act == ACT_STEP_NEXT);
              if (is_slot(cur_r)) begin
                rd_en = 1'b1;
              end else begin
                stat_nxt = STAT_NOCUR;
              end
            end
            ACT_REMOVE: begin
              if (is_slot(cur_r)) begin
                rd_en = 1'b1;
              end else begin
                stat_nxt = STAT_NOCUR;
              end
            end
            default: begin
              // Clear: drop list, free list and cursor; direction back to forward
              head_nxt  = NIL;
              tail_nxt  = NIL;
              cur_nxt   = NIL;
              dir_nxt   = 1'b1;
              free_nxt  = NIL;
              fresh_nxt = '0;
              count_nxt = '0;
            end
          endcase
        end
      end

      ST_LINK: begin
        case (act_r)
          ACT_PUSH: begin
            if (slot_avail) begin
              if (is_slot(free_r)) begin
                free_nxt = rd_fwd_r;
              end else begin
                fresh_nxt = fresh_r + PW'(1);
              end
              wd_we   = 1'b1;
              fw_we   = 1'b1;
              fw_addr = push_slot[AW-1:0];
              fw_data = NIL;
              bw_we   = 1'b1;
              tail_nxt  = push_slot;
              count_nxt = count_r + PW'(1);
              // Old tail gets its forward link in the next cycle
              wr2_addr_nxt = tail_r;
              wr2_data_nxt = push_slot;
              if (!is_slot(tail_r)) begin
                head_nxt = push_slot;
              end
            end else begin
              stat_nxt = STAT_FULL;
            end
          end
          ACT_POP: begin
            head_nxt = rd_fwd_r;
            if (is_slot(rd_fwd_r)) begin
              bw_we   = 1'b1;
              bw_addr = rd_fwd_r[AW-1:0];
              bw_data = NIL;
            end else begin
              tail_nxt = NIL;
            end
            // Return the old head to the free list
            fw_we   = 1'b1;
            fw_addr = head_r[AW-1:0];
            fw_data = free_r;
            free_nxt = head_r;
            if (count_r != '0) begin
              count_nxt = count_r - PW'(1);
            end
          end
          ACT_STEP_NEXT, ACT_STEP_PREV: begin
            cur_nxt = step_sel;
            rd_en   = 1'b1;
            rd_addr = step_sel[AW-1:0];
          end
          ACT_REMOVE: begin
            // Unlink: rd_bwd_r is the predecessor, rd_fwd_r the successor
            if (is_slot(rd_bwd_r)) begin
              fw_we   = 1'b1;
              fw_addr = rd_bwd_r[AW-1:0];
              fw_data = rd_fwd_r;
            end else begin
              head_nxt = rd_fwd_r;
            end
            if (is_slot(rd_fwd_r)) begin
              bw_we   = 1'b1;
              bw_addr = rd_fwd_r[AW-1:0];
              bw_data = rd_bwd_r;
            end else begin
              tail_nxt = rd_bwd_r;
            end
            cur_nxt = rm_sel;
            if (count_r != '0) begin
              count_nxt = count_r - PW'(1);
            end
            wr2_addr_nxt = cur_r;
            wr2_data_nxt = free_r;
          end
          default: begin
          end
        endcase
      end

      ST_WR2: begin
        // Second forward-link write; fetch the word under the cursor meanwhile
        fw_we = 1'b1;
        rd_en = 1'b1;
        if (act_r == ACT_REMOVE) begin
          free_nxt = wr2_addr_r;
        end
      end

      ST_RES: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = stat_r;
          out_word_nxt   = res_wv ? rd_word_r : '0;
          out_wv_nxt     = res_wv;
          out_cv_nxt     = is_slot(cur_r);
          out_occ_nxt    = count_r;
        end
      end

      default: begin
      end
    endcase
  end

  // Slot store
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= word_mem[rd_addr];
      rd_fwd_r  <= fwd_mem[rd_addr];
      rd_bwd_r  <= bwd_mem[rd_addr];
    end
    if (wd_we) begin
      word_mem[wd_addr] <= wd_data;
    end
    if (fw_we) begin
      fwd_mem[fw_addr] <= fw_data;
    end
    if (bw_we) begin
      bwd_mem[bw_addr] <= bw_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= NIL;
      tail_r       <= NIL;
      cur_r        <= NIL;
      dir_r        <= 1'b1;
      free_r       <= NIL;
      fresh_r      <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cur_r        <= cur_nxt;
      dir_r        <= dir_nxt;
      free_r       <= free_nxt;
      fresh_r      <= fresh_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    data_r     <= data_nxt;
    stat_r     <= stat_nxt;
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_word_r <= out_word_nxt;
    out_wv_r   <= out_wv_nxt;
    out_cv_r   <= out_cv_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_occ_r, out_word_r};
  assign out_tuser  = {out_cv_r, out_wv_r, out_stat_r};

  `ASSERT_RST(a_rst_idle, clk, !rst_n |=> state_r == ST_IDLE, "reset did not idle the sequencer")
  `ASSERT_CHK(a_cnt_bound, clk, rst_n, count_r <= fresh_r && fresh_r <= NIL, "entry count beyond slots used")
  `ASSERT_CHK(a_ends, clk, rst_n, is_slot(head_r) == is_slot(tail_r), "head and tail disagree on emptiness")
  `ASSERT_CHK(a_empty, clk, rst_n, (count_r == '0) == !is_slot(head_r), "entry count disagrees with head")
  `ASSERT_CHK(a_cursor, clk, rst_n, is_slot(cur_r) |-> count_r != '0, "cursor set on an empty queue")

endmodule
